@@ sv/lstw_pkg.sv @@
// Shared types, constants and the sine preset for the line stroke table writer.
package lstw_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int PRESET_MAX = 4096;
	localparam int PAD = 40;
	localparam int MIN_VIEW = 81;
	localparam int NUM_W = 30;
	localparam int BIT_W = $clog2(NUM_W);

	localparam logic [1:0] REG_VIEW_WIDTH = 2'd0;
	localparam logic [1:0] REG_VIEW_HEIGHT = 2'd1;
	localparam logic [1:0] REG_VALUE_FLOOR = 2'd2;
	localparam logic [1:0] REG_VALUE_CEILING = 2'd3;

	localparam longint ROT_COS = 64'sd1068377587;
	localparam longint ROT_SIN = 64'sd107195315;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_RDDATA,
		ST_MULX,
		ST_DIVX,
		ST_CHKX,
		ST_MULY,
		ST_DIVY,
		ST_WRITE,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef logic signed [15:0] preset_t [PRESET_MAX];

	// divide by 2^sh, rounding half away from zero
	function automatic longint round_shift(longint v, int sh);
		longint half;
		half = longint'(1) <<< (sh - 1);
		return (v >= 0) ? ((v + half) >>> sh) : -((half - v) >>> sh);
	endfunction

	// sine by repeated Q30 rotation, 0.5 + 0.5*sin(0.1*i) in Q4.12
	function automatic preset_t sine_preset();
		preset_t t;
		longint c;
		longint s;
		longint nc;
		longint ns;
		c = longint'(1) <<< 30;
		s = 0;
		for (int i = 0; i < PRESET_MAX; i++) begin
			t[i] = 16'(64'sd2048 + round_shift(s, 19));
			nc = round_shift(c * ROT_COS - s * ROT_SIN, 30);
			ns = round_shift(s * ROT_COS + c * ROT_SIN, 30);
			c = nc;
			s = ns;
		end
		return t;
	endfunction

endpackage

@@ sv/line_stroke_table_writer.sv @@
// Stroke-driven value table: Bresenham walk with a shared multiplier and serial divider.
// Read transaction: from accept through ST_RD and ST_RDDATA to the result register.
// Stroke transaction: each in-range pixel runs two restoring divisions (x, then y)
// through the one shared divider; a skipped pixel runs only the x division.
// One transaction in flight; the next is taken once the result is registered.
// After reset the table is filled with the sine preset, one entry a cycle,
// with the input stalled meanwhile.
module line_stroke_table_writer #(
	parameter int TABLE_ENTRIES = lstw_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [12:0] start_x,
	input  logic signed [12:0] start_y,
	input  logic signed [12:0] end_x,
	input  logic signed [12:0] end_y,
	input  logic [6:0]         read_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] read_value,
	output logic [13:0]        points_written
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int NW = lstw_pkg::NUM_W;
	localparam int BW = lstw_pkg::BIT_W;
	localparam lstw_pkg::preset_t PRESET = lstw_pkg::sine_preset();

	lstw_pkg::state_t state_q, state_d;

	logic [11:0]        width_q, height_q;
	logic signed [15:0] floor_q, ceil_q;
	logic [11:0]        wd, hd;

	logic signed [12:0] x_q, y_q, x2_q, y2_q;
	logic [13:0]        dx_q, dy_q;
	logic               sx_neg_q, sy_neg_q;
	logic signed [15:0] err_q;
	logic [13:0]        count_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      init_q;
	logic [6:0]         rd_index_q;
	logic               rd_ok_q;
	logic signed [15:0] rd_data_q;

	logic [NW-1:0]      num_q;
	logic               neg_q;
	logic [11:0]        rem_q;
	logic [11:0]        div_q;
	logic [BW-1:0]      bit_q;

	logic               out_valid_q;
	logic signed [15:0] read_value_q;
	logic [13:0]        points_written_q;
	logic signed [15:0] res_val_q;
	logic [13:0]        res_cnt_q;

	logic signed [15:0] value_table [TABLE_ENTRIES];

	logic               accept, cfg_wr;
	logic signed [13:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [16:0] range_diff;
	logic signed [31:0] prod, prod_mag;
	logic [12:0]        trial, trial_sub;
	logic               trial_ge;
	logic               idx_ok;
	logic signed [31:0] q_signed, v_raw, v_hi;
	logic signed [15:0] v_clamped;
	logic signed [16:0] e2, err_next;
	logic               step_x, step_y;
	logic               at_end;
	logic signed [13:0] sdx, sdy;

	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic signed [15:0] mem_wdata;
	logic               out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign accept = in_valid & ~in_stall;

	always_comb begin
		unique case (paddr[3:2])
			lstw_pkg::REG_VIEW_WIDTH:    prdata = {20'd0, width_q};
			lstw_pkg::REG_VIEW_HEIGHT:   prdata = {20'd0, height_q};
			lstw_pkg::REG_VALUE_FLOOR:   prdata = 32'(floor_q);
			lstw_pkg::REG_VALUE_CEILING: prdata = 32'(ceil_q);
			default:                     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd800;
			height_q <= 12'd600;
			floor_q  <= 16'sd0;
			ceil_q   <= 16'sd4096;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lstw_pkg::REG_VIEW_WIDTH:    width_q <= pwdata[11:0];
				lstw_pkg::REG_VIEW_HEIGHT:   height_q <= pwdata[11:0];
				lstw_pkg::REG_VALUE_FLOOR:   floor_q <= pwdata[15:0];
				lstw_pkg::REG_VALUE_CEILING: ceil_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// divisors, narrow windows treated as the minimum width
	assign wd = (width_q < 12'(lstw_pkg::MIN_VIEW)) ? 12'd1 :
		width_q - 12'(2 * lstw_pkg::PAD);
	assign hd = (height_q < 12'(lstw_pkg::MIN_VIEW)) ? 12'd1 :
		height_q - 12'(2 * lstw_pkg::PAD);

	// shared multiplier
	assign range_diff = 17'(ceil_q) - 17'(floor_q);
	assign mul_a = (state_q == lstw_pkg::ST_MULY) ?
		14'(y_q) - 14'sd40 : 14'(x_q) - 14'sd40;
	assign mul_b = (state_q == lstw_pkg::ST_MULY) ?
		18'(range_diff) : 18'(TABLE_ENTRIES - 1);
	assign prod = 32'(mul_a) * 32'(mul_b);
	assign prod_mag = prod[31] ? -prod : prod;

	// shared restoring divider, one quotient bit a cycle
	assign trial = {rem_q, num_q[NW-1]};
	assign trial_ge = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	assign idx_ok = (num_q == '0) || (!neg_q && num_q < NW'(TABLE_ENTRIES));

	assign q_signed = neg_q ? -(32'(num_q)) : 32'(num_q);
	assign v_raw = 32'(ceil_q) - q_signed;
	assign v_hi = (v_raw > 32'(ceil_q)) ? 32'(ceil_q) : v_raw;
	assign v_clamped = (v_hi < 32'(floor_q)) ? floor_q : v_hi[15:0];

	// Bresenham step
	assign e2 = {err_q, 1'b0};
	assign step_x = e2 > -$signed({3'b000, dy_q});
	assign step_y = e2 < $signed({3'b000, dx_q});
	assign err_next = 17'(err_q) - (step_x ? $signed({3'b000, dy_q}) : 17'sd0)
		+ (step_y ? $signed({3'b000, dx_q}) : 17'sd0);
	assign at_end = (x_q == x2_q) && (y_q == y2_q);

	assign sdx = 14'(end_x) - 14'(start_x);
	assign sdy = 14'(end_y) - 14'(start_y);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lstw_pkg::ST_INIT:
				if (init_q == IW'(TABLE_ENTRIES - 1)) state_d = lstw_pkg::ST_IDLE;
			lstw_pkg::ST_IDLE:
				if (accept) state_d = command ? lstw_pkg::ST_RD : lstw_pkg::ST_MULX;
			lstw_pkg::ST_RD:     state_d = lstw_pkg::ST_RDDATA;
			lstw_pkg::ST_RDDATA: state_d = lstw_pkg::ST_DONE;
			lstw_pkg::ST_MULX:   state_d = lstw_pkg::ST_DIVX;
			lstw_pkg::ST_DIVX:
				if (bit_q == '0) state_d = lstw_pkg::ST_CHKX;
			lstw_pkg::ST_CHKX:
				state_d = idx_ok ? lstw_pkg::ST_MULY : lstw_pkg::ST_STEP;
			lstw_pkg::ST_MULY:   state_d = lstw_pkg::ST_DIVY;
			lstw_pkg::ST_DIVY:
				if (bit_q == '0) state_d = lstw_pkg::ST_WRITE;
			lstw_pkg::ST_WRITE:  state_d = lstw_pkg::ST_STEP;
			lstw_pkg::ST_STEP:
				state_d = at_end ? lstw_pkg::ST_DONE : lstw_pkg::ST_MULX;
			lstw_pkg::ST_DONE:
				if (!out_valid_q || !out_stall) state_d = lstw_pkg::ST_IDLE;
			default: state_d = lstw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != lstw_pkg::ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = v_clamped;
		out_load  = 1'b0;
		unique case (state_q)
			lstw_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_q;
				mem_wdata = PRESET[init_q];
			end
			lstw_pkg::ST_WRITE: mem_we = 1'b1;
			lstw_pkg::ST_DONE:  out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lstw_pkg::ST_INIT;
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lstw_pkg::ST_INIT) init_q <= init_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) value_table[mem_waddr] <= mem_wdata;
		if (state_q == lstw_pkg::ST_RD) rd_data_q <= value_table[IW'(rd_index_q)];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			read_value_q     <= res_val_q;
			points_written_q <= res_cnt_q;
		end
		case (state_q)
			lstw_pkg::ST_IDLE:
				if (accept) begin
					rd_index_q <= read_index;
					rd_ok_q    <= 32'(read_index) < TABLE_ENTRIES;
					x_q        <= start_x;
					y_q        <= start_y;
					x2_q       <= end_x;
					y2_q       <= end_y;
					dx_q       <= sdx[13] ? 14'(-sdx) : 14'(sdx);
					dy_q       <= sdy[13] ? 14'(-sdy) : 14'(sdy);
					sx_neg_q   <= !(start_x < end_x);
					sy_neg_q   <= !(start_y < end_y);
					err_q      <= 16'(sdx[13] ? -sdx : sdx) - 16'(sdy[13] ? -sdy : sdy);
					count_q    <= '0;
				end
			lstw_pkg::ST_RDDATA: begin
				res_val_q <= rd_ok_q ? rd_data_q : 16'sd0;
				res_cnt_q <= '0;
			end
			lstw_pkg::ST_MULX, lstw_pkg::ST_MULY: begin
				num_q <= prod_mag[NW-1:0];
				neg_q <= prod[31];
				rem_q <= '0;
				bit_q <= BW'(NW - 1);
				div_q <= (state_q == lstw_pkg::ST_MULY) ? hd : wd;
			end
			lstw_pkg::ST_DIVX, lstw_pkg::ST_DIVY: begin
				rem_q <= trial_ge ? trial_sub[11:0] : trial[11:0];
				num_q <= {num_q[NW-2:0], trial_ge};
				bit_q <= bit_q - 1'b1;
			end
			lstw_pkg::ST_CHKX: idx_q <= num_q[IW-1:0];
			lstw_pkg::ST_WRITE: count_q <= count_q + 1'b1;
			lstw_pkg::ST_STEP:
				if (at_end) begin
					res_val_q <= 16'sd0;
					res_cnt_q <= count_q;
				end else begin
					err_q <= err_next[15:0];
					if (step_x) x_q <= sx_neg_q ? x_q - 13'sd1 : x_q + 13'sd1;
					if (step_y) y_q <= sy_neg_q ? y_q - 13'sd1 : y_q + 13'sd1;
				end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign points_written = points_written_q;

endmodule
